// File: rtl/core/cha_pkg.sv
// Shared constants, types and the CORDIC angle table for the heading unit.
`default_nettype none
package cha_pkg;
  localparam int SamplesPerHeading = 10;
  localparam int CordicSteps       = 16;
  localparam int SumW              = 17;
  localparam int CntW              = 4;
  localparam int ZW                = 26;
  localparam int CW                = 20;
  localparam int StepW             = 4;

  // Reciprocal of the group size, scaled by 2^AvgShift and rounded up.
  localparam int AvgShift          = 19;
  localparam int AvgRecip          = ((1 << AvgShift) + SamplesPerHeading - 1) /
                                     SamplesPerHeading;

  localparam logic [1:0] RegMinX = 2'd0;
  localparam logic [1:0] RegMaxX = 2'd1;
  localparam logic [1:0] RegMinY = 2'd2;
  localparam logic [1:0] RegMaxY = 2'd3;

  localparam logic signed [ZW-1:0] Deg180 = ZW'(180 * 32768);
  localparam logic signed [ZW-1:0] Deg360 = ZW'(360 * 32768);

  typedef struct packed {
    logic acc;
    logic clr;
    logic avg;
    logic div_start;
    logic cordic_init;
    logic cordic_step;
    logic finish;
  } cha_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_step;
  } cha_sts_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [StepW-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      4'd0: v = 26'sd1474560;
      4'd1: v = 26'sd870484;
      4'd2: v = 26'sd459940;
      4'd3: v = 26'sd233473;
      4'd4: v = 26'sd117189;
      4'd5: v = 26'sd58652;
      4'd6: v = 26'sd29333;
      4'd7: v = 26'sd14667;
      4'd8: v = 26'sd7334;
      4'd9: v = 26'sd3667;
      4'd10: v = 26'sd1833;
      4'd11: v = 26'sd917;
      4'd12: v = 26'sd458;
      4'd13: v = 26'sd229;
      4'd14: v = 26'sd115;
      default: v = 26'sd57;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/compass_heading_average_unit.sv
// Top level of the averaged, calibrated compass heading unit.
// Usage:
//   s_axis carries raw samples: tdata[11:0] mag_x, tdata[23:12] mag_y.
//   Every tenth accepted item produces one heading item on m_axis:
//   tdata[15:0] heading in degrees (unsigned Q9.7), tuser[0] degenerate
//   (set when a calibration axis has max equal to min).
//   cfg channel writes min_x, max_x, min_y, max_y by index 0..3; it is
//   ready only while the unit waits for samples.
// Timing:
//   Samples of a group are taken back to back, one per cycle. The tenth
//   sample is followed by an averaging step (reciprocal multiply), a
//   launch step, two divisions in a shared radix-2 divider (32 iterations
//   plus a registered result, one per axis scaling), a CORDIC load, 16
//   CORDIC iterations and a rounding step; no sample of the next group is
//   accepted until the heading item has been taken.
// Reset:
//   Sums and count clear; calibration returns to -2048 / 2047.
// Stall:
//   The result holds on m_axis until taken; no new item is accepted
//   meanwhile.
`default_nettype none
module compass_heading_average_unit import cha_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // mag_x [11:0], mag_y [23:12]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // heading_deg [15:0]
  output logic             m_axis_tuser,   // degenerate
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);
  logic signed [11:0] min_x_q, max_x_q, min_y_q, max_y_q;
  cha_cmd_t cmd;
  cha_sts_t sts;
  logic in_fire;

  // Hold calibration steady while a group is being processed.
  assign cfg_ready_o = s_axis_tready;
  assign in_fire = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= -12'sd2048; max_x_q <= 12'sd2047;
      min_y_q <= -12'sd2048; max_y_q <= 12'sd2047;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegMinX: min_x_q <= $signed(cfg_data_i);
          RegMaxX: max_x_q <= $signed(cfg_data_i);
          RegMinY: min_y_q <= $signed(cfg_data_i);
          RegMaxY: max_y_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  cha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_ready_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid)
  );

  cha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .mag_x_i(s_axis_tdata[11:0]), .mag_y_i(s_axis_tdata[23:12]),
    .min_x_i(min_x_q), .max_x_i(max_x_q), .min_y_i(min_y_q), .max_y_i(max_y_q),
    .heading_o(m_axis_tdata), .degen_o(m_axis_tuser)
  );
endmodule
`default_nettype wire

// File: rtl/core/cha_div.sv
// Iterative signed divider, truncating toward zero, one quotient bit a cycle.
`default_nettype none
module cha_div import cha_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] num_i,
  input  wire logic signed [15:0] den_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [31:0]      quo_o
);
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d;
  logic        done_q, done_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d;
  logic [15:0] den_q, den_d;
  logic [32:0] trial;
  logic [31:0] rsh;

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; neg_d = neg_q;
    rem_d = rem_q; quo_d = quo_q; den_d = den_q;
    rsh = {rem_q[30:0], quo_q[31]};
    trial = {1'b0, rsh} - {17'd0, den_q};
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      rem_d  = '0;
      quo_d  = num_i[31] ? 32'(-num_i) : num_i;
      den_d  = den_i[15] ? 16'(-den_i) : den_i;
      neg_d  = num_i[31] ^ den_i[15];
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rsh;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // The quotient is final in the cycle that done is high.
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = neg_q ? 32'(-quo_q) : quo_q;
endmodule
`default_nettype wire

// File: rtl/core/cha_datapath.sv
// Datapath: sums, averaging, axis scaling, CORDIC and degree rounding.
`default_nettype none
module cha_datapath import cha_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cha_cmd_t           cmd_i,
  output cha_sts_t                sts_o,
  input  wire logic signed [11:0] mag_x_i,
  input  wire logic signed [11:0] mag_y_i,
  input  wire logic signed [11:0] min_x_i,
  input  wire logic signed [11:0] max_x_i,
  input  wire logic signed [11:0] min_y_i,
  input  wire logic signed [11:0] max_y_i,
  output logic [15:0]             heading_o,
  output logic                    degen_o
);
  logic signed [SumW-1:0] sum_x_q, sum_y_q;
  logic signed [15:0] sx_q, sy_q;
  logic signed [CW-1:0] cx_q, cy_q;
  logic signed [ZW-1:0] z_q;
  logic [StepW-1:0] step_q;
  logic zero_q, degen_q;
  logic [15:0] head_q;
  logic div_sel_q;   // axis whose scaling is in the divider: 0 x, 1 y
  logic signed [11:0] avg_x_q, avg_y_q;

  logic div_start, div_busy, div_done;
  logic signed [31:0] num, quo;
  logic signed [15:0] den;
  logic signed [12:0] span_x, span_y;

  assign span_x = 13'(max_x_i) - 13'(min_x_i);
  assign span_y = 13'(max_y_i) - 13'(min_y_i);

  // Divide a sum by the group size, truncating toward zero.
  function automatic logic signed [11:0] avg_of(input logic signed [SumW-1:0] s);
    logic [SumW-1:0] mag;
    logic [39:0]     prod;
    logic [11:0]     q;
    mag  = s[SumW-1] ? SumW'(-s) : SumW'(s);
    prod = 40'(mag) * 40'(AvgRecip);
    q    = prod[AvgShift+11:AvgShift];
    return s[SumW-1] ? $signed(~q + 12'd1) : $signed(q);
  endfunction

  // The x scaling is launched by the controller, the y scaling when x is done.
  always_comb begin
    if (cmd_i.div_start) begin
      num = (32'(2) * (32'(avg_x_q) - 32'(min_x_i)) - 32'(span_x)) <<< 14;
      den = 16'(span_x);
    end else begin
      num = (32'(2) * (32'(avg_y_q) - 32'(min_y_i)) - 32'(span_y)) <<< 14;
      den = 16'(span_y);
    end
  end

  assign div_start = cmd_i.div_start | (div_done & !div_sel_q);

  cha_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(den),
    .busy_o(div_busy), .done_o(div_done), .quo_o(quo)
  );

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sd32767;
    if (v < -32'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  logic signed [CW-1:0] shx, shy, nx, ny;
  logic signed [ZW-1:0] nz, zw;
  logic signed [ZW:0] zr;
  assign shx = cx_q >>> step_q;
  assign shy = cy_q >>> step_q;
  always_comb begin
    if (cy_q > 0) begin
      nx = cx_q + shy; ny = cy_q - shx; nz = z_q + atan_lut(step_q);
    end else begin
      nx = cx_q - shy; ny = cy_q + shx; nz = z_q - atan_lut(step_q);
    end
    zw = z_q;
    if (z_q < 0) zw = z_q + Deg360;
    else if (z_q >= Deg360) zw = z_q - Deg360;
    zr = ((ZW+1)'(zw) + (ZW+1)'(128)) >>> 8;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0; sum_y_q <= '0; div_sel_q <= 1'b0; step_q <= '0;
    end else begin
      if (cmd_i.clr) begin
        sum_x_q <= '0; sum_y_q <= '0;
      end else if (cmd_i.acc) begin
        sum_x_q <= sum_x_q + SumW'(mag_x_i);
        sum_y_q <= sum_y_q + SumW'(mag_y_i);
      end
      if (cmd_i.div_start) div_sel_q <= 1'b0;
      else if (div_start) div_sel_q <= 1'b1;
      if (cmd_i.cordic_init) step_q <= '0;
      else if (cmd_i.cordic_step) step_q <= step_q + StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.avg) begin
      avg_x_q <= avg_of(sum_x_q);
      avg_y_q <= avg_of(sum_y_q);
    end
    if (div_done) begin
      if (!div_sel_q) sx_q <= (span_x == 0) ? 16'sd0 : sat16(quo);
      else sy_q <= (span_y == 0) ? 16'sd0 : sat16(quo);
    end
    if (cmd_i.cordic_init) begin
      zero_q <= (sx_q == 0) && (sy_q == 0);
      degen_q <= (span_x == 0) || (span_y == 0);
      if (sx_q < 0) begin
        cx_q <= -CW'(sx_q); cy_q <= -CW'(sy_q); z_q <= Deg180;
      end else begin
        cx_q <= CW'(sx_q); cy_q <= CW'(sy_q); z_q <= '0;
      end
    end else if (cmd_i.cordic_step) begin
      cx_q <= nx; cy_q <= ny; z_q <= nz;
    end
    if (cmd_i.finish)
      head_q <= (zero_q || zr >= (ZW+1)'(46080)) ? 16'd0 : zr[15:0];
  end

  assign sts_o.div_done  = div_done && div_sel_q && !div_busy;
  assign sts_o.last_step = step_q == StepW'(CordicSteps - 1);
  assign heading_o = head_q;
  assign degen_o   = degen_q;
endmodule
`default_nettype wire

// File: rtl/core/cha_ctrl.sv
// Controller state machine sequencing accumulate, divide, CORDIC and output.
`default_nettype none
module cha_ctrl import cha_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_fire_i,
  input  wire logic     out_ready_i,
  input  wire cha_sts_t sts_i,
  output cha_cmd_t      cmd_o,
  output logic          in_ready_o,
  output logic          out_valid_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StAvg  = 3'd1;
  localparam logic [2:0] StKick = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StInit = 3'd4;
  localparam logic [2:0] StCord = 3'd5;
  localparam logic [2:0] StFin  = 3'd6;
  localparam logic [2:0] StOut  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic last;

  assign last = cnt_q == CntW'(SamplesPerHeading - 1);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    in_ready_o = state_q == StIdle;
    out_valid_o = state_q == StOut;
    case (state_q)
      StIdle: if (in_fire_i) begin
        cmd_o.acc = 1'b1;
        cnt_d = last ? '0 : cnt_q + CntW'(1);
        if (last) state_d = StAvg;
      end
      StAvg: begin
        // Take the averages and clear the sums for the next group.
        cmd_o.avg = 1'b1;
        cmd_o.clr = 1'b1;
        state_d = StKick;
      end
      StKick: begin
        cmd_o.div_start = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        if (sts_i.div_done) state_d = StInit;
      end
      StInit: begin
        cmd_o.cordic_init = 1'b1;
        state_d = StCord;
      end
      StCord: begin
        cmd_o.cordic_step = 1'b1;
        if (sts_i.last_step) state_d = StFin;
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        state_d = StOut;
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |-> state_q == StIdle) else $error("item taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CntW'(SamplesPerHeading)) else $error("count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StFin |=> state_q == StOut) else $error("finish not followed by output");
endmodule
`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the averaged, calibrated compass heading unit.
`default_nettype none
module tb import cha_pkg::*; ();

  localparam int Group      = SamplesPerHeading;
  localparam int IdleLimit  = 20000;
  localparam int DrainWait  = 400;

  typedef struct {
    logic [15:0] heading;
    logic        degen;
  } heading_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;

  compass_heading_average_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: calibration and running sums.
  int cal_min_x, cal_max_x, cal_min_y, cal_max_y;
  int acc_x, acc_y, acc_cnt;

  logic [23:0] sample_q[$];
  heading_t    heading_q[$];
  int          n_fail;
  int          idle_cycles;
  bit          hold_off_req;

  localparam longint AtanTab[CordicSteps] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57};

  function automatic longint scale_axis(input longint avg, input longint lo,
                                        input longint hi, inout bit degen);
    longint span, q;
    span = hi - lo;
    if (span == 0) begin
      degen = 1'b1;
      return 0;
    end
    q = ((2 * (avg - lo) - span) * 16384) / span;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q;
  endfunction

  function automatic logic [15:0] heading_of(input longint x, input longint y);
    longint z, nx, r;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 180 * 32768;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += AtanTab[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= AtanTab[i];
      end
      x = nx;
    end
    while (z < 0) z += 360 * 32768;
    while (z >= 360 * 32768) z -= 360 * 32768;
    r = (z + 128) >>> 8;
    if (r >= 46080) r = 0;
    return r[15:0];
  endfunction

  // Advance the running sums; push a heading on every completed group.
  function automatic void predict_sample(input logic [23:0] d);
    heading_t h;
    bit       dg;
    longint   sx, sy;
    dg = 1'b0;
    acc_x += int'($signed(d[11:0]));
    acc_y += int'($signed(d[23:12]));
    acc_cnt++;
    if (acc_cnt < Group) return;
    sx = scale_axis(acc_x / Group, cal_min_x, cal_max_x, dg);
    sy = scale_axis(acc_y / Group, cal_min_y, cal_max_y, dg);
    h.heading = heading_of(sx, sy);
    h.degen   = dg;
    heading_q.push_back(h);
    acc_x = 0;
    acc_y = 0;
    acc_cnt = 0;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // Sample driver: offer queued items with random gaps.
  int src_gap;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predict_sample(s_axis_tdata);
      void'(sample_q.pop_front());
    end
    if (src_gap > 0) begin
      src_gap <= src_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if ((s_axis_tvalid && s_axis_tready) || !s_axis_tvalid) begin
      // next item: skip the one just taken
      if (s_axis_tvalid && s_axis_tready) begin
        if (sample_q.size() > 0 && gap_len() == 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= sample_q[0];
        end else begin
          s_axis_tvalid <= 1'b0;
          src_gap <= gap_len();
        end
      end else if (sample_q.size() > 0 && rst_ni) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample_q[0];
      end
    end
  end

  // Heading monitor with random back-pressure and long hold-offs while requested.
  int sink_gap;
  int hold_cnt;
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (heading_q.size() == 0) begin
        $error("unexpected heading item: heading_deg=%0d", m_axis_tdata);
        n_fail++;
      end else begin
        if (m_axis_tdata !== heading_q[0].heading) begin
          $error("heading_deg: expected %0d, got %0d", heading_q[0].heading,
                 m_axis_tdata);
          n_fail++;
        end
        if (m_axis_tuser !== heading_q[0].degen) begin
          $error("degenerate: expected %0d, got %0d", heading_q[0].degen,
                 m_axis_tuser);
          n_fail++;
        end
        void'(heading_q.pop_front());
      end
    end
    if (hold_off_req && hold_cnt == 0) begin
      hold_cnt <= 3000;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= (hold_cnt == 1);
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(3) == 0) sink_gap <= gap_len();
    end
  end

  // Watchdog: count cycles with no accepted item on any channel and no hold-off running.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || hold_cnt > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_cal(input logic [1:0] idx, input int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[11:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegMinX: cal_min_x = val;
      RegMaxX: cal_max_x = val;
      RegMinY: cal_min_y = val;
      default: cal_max_y = val;
    endcase
  endtask

  task automatic set_cal(input int mnx, input int mxx, input int mny, input int mxy);
    write_cal(RegMinX, mnx);
    write_cal(RegMaxX, mxx);
    write_cal(RegMinY, mny);
    write_cal(RegMaxY, mxy);
  endtask

  // Wait until the queue has drained and every heading has come back.
  task automatic drain();
    while (sample_q.size() > 0 || s_axis_tvalid || heading_q.size() > 0 ||
           acc_cnt != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  // One group of ten samples near (cx, cy) with random spread.
  task automatic push_group(input int cx, input int cy, input int spread);
    int x, y;
    for (int k = 0; k < Group; k++) begin
      x = cx + $signed($urandom_range(2 * spread)) - spread;
      y = cy + $signed($urandom_range(2 * spread)) - spread;
      if (x > 2047) x = 2047;
      if (x < -2048) x = -2048;
      if (y > 2047) y = 2047;
      if (y < -2048) y = -2048;
      sample_q.push_back({y[11:0], x[11:0]});
    end
  endtask

  task automatic push_raw_groups(input int n);
    for (int k = 0; k < n * Group; k++)
      sample_q.push_back(24'($urandom));
  endtask

  task automatic random_cal();
    int a, b;
    int pick;
    pick = $urandom_range(9);
    a = $signed($urandom_range(4095)) - 2048;
    b = $signed($urandom_range(4095)) - 2048;
    if (pick == 0) b = a;                   // degenerate axis
    set_cal(a, b, -200 - $urandom_range(1500), 200 + $urandom_range(1500));
  endtask

  initial begin
    cal_min_x = -2048; cal_max_x = 2047;
    cal_min_y = -2048; cal_max_y = 2047;
    acc_x = 0; acc_y = 0; acc_cnt = 0;
    n_fail = 0; idle_cycles = 0; hold_off_req = 0;
    src_gap = 0; sink_gap = 0; hold_cnt = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, origin, each quadrant, saturation.
    push_group(2047, 2047, 0);
    push_group(-2048, -2048, 0);
    sample_q.push_back({12'h000, 12'h000});
    for (int k = 1; k < Group; k++) sample_q.push_back({12'h800, 12'h7ff});
    drain();
    set_cal(0, 0, -10, 10);                 // x degenerate
    push_group(500, -5, 0);
    drain();
    set_cal(100, -100, 2047, -2048);        // spans below zero
    push_group(-30, 1500, 3);
    drain();
    set_cal(-1, 1, -1, 1);                  // average far outside: saturate
    push_group(-2048, 2047, 0);
    drain();
    set_cal(-500, 500, -500, 500);
    push_group(0, 0, 0);                    // both axes zero
    push_group(-400, 1, 0);                 // negative x
    push_group(-400, -1, 0);
    drain();

    // Random phases; long receiver hold-offs land in the second one.
    for (int ph = 0; ph < 5; ph++) begin
      random_cal();
      for (int g = 0; g < 7; g++) begin
        if ($urandom_range(4) == 0) push_raw_groups(1);
        else push_group($signed($urandom_range(3000)) - 1500,
                        $signed($urandom_range(3000)) - 1500, $urandom_range(300));
      end
      if (ph == 1) hold_off_req = 1'b1;
      while (sample_q.size() > 30) @(posedge clk_i);
      hold_off_req = 1'b0;
      drain();
    end
    set_cal(-2048, 2047, -2048, 2047);
    push_raw_groups(2);
    drain();

    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
rtl/core/cha_pkg.sv
rtl/core/cha_div.sv
rtl/core/cha_datapath.sv
rtl/core/cha_ctrl.sv
rtl/core/compass_heading_average_unit.sv
dv/tb.sv
